// ===== hw/rtl/sgb_pkg.sv =====
// Shared constants for the scaled glyph blitter: default frame geometry,
// glyph limits, datapath widths and operation codes. No dependencies.
package sgb_pkg;

    // Default frame and glyph geometry.
    localparam int DEF_FRAME_WIDTH  = 128;
    localparam int DEF_FRAME_HEIGHT = 64;
    localparam int DEF_GLYPH_COLS   = 5;
    localparam int DEF_GLYPH_ROWS   = 8;

    // One frame byte covers a band of eight rows.
    localparam int BAND_ROWS = 8;
    localparam int BYTE_W    = 8;

    // Field widths fixed by the interface.
    localparam int POS_W    = 10;
    localparam int SCALE_W  = 4;
    localparam int GLYPH_W  = 40;
    localparam int FUNC_W   = 2;

    // Working coordinate width: origin plus the largest glyph offset.
    localparam int COORD_W  = 11;

    // Scale after reset.
    localparam logic [SCALE_W-1:0] SCALE_RESET = 4'd1;

    // Operation carried by an item.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_PIXEL = 2'd1,
        FUNC_GLYPH = 2'd2,
        FUNC_READ  = 2'd3
    } t_func;

endpackage

// ===== hw/rtl/sgb_frame_ram.sv =====
// Single-port frame buffer memory with registered read data.
// Depends on sgb_pkg for the byte width.
module sgb_frame_ram
    import sgb_pkg::*;
#(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [BYTE_W-1:0] i_wdata,
    output logic [BYTE_W-1:0] o_rdata
);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    // One access per cycle: write or registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/scaled_glyph_blitter.sv =====
// Scaled glyph blitter: page-ordered monochrome frame buffer with clear, pixel,
// glyph and read operations, all sharing the single memory port. Clipped pixels
// skip the memory; a glyph at scale zero finishes without drawing. One item at a
// time; busy is high until its result strobe, but a scale-zero glyph or an
// out-of-range read strobes without raising busy. Reset starts a clearing pass
// over STORE_BYTES bytes (1024 by default), busy high; the receiver cannot stall.
module scaled_glyph_blitter
    import sgb_pkg::*;
#(
    parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT,
    parameter int GLYPH_COLS   = DEF_GLYPH_COLS,
    parameter int GLYPH_ROWS   = DEF_GLYPH_ROWS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [SCALE_W-1:0] i_cfg_wdata,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [POS_W-1:0]   i_pos_x,
    input  logic [POS_W-1:0]   i_pos_y,
    input  logic               i_pixel_on,
    input  logic [GLYPH_W-1:0] i_glyph_bits,
    input  logic [POS_W-1:0]   i_byte_index,
    output logic               o_done,
    output logic [BYTE_W-1:0]  o_read_byte,
    output logic               o_is_read
);

    localparam int BAND_COUNT  = (FRAME_HEIGHT + BAND_ROWS - 1) / BAND_ROWS;
    localparam int STORE_BYTES = FRAME_WIDTH * BAND_COUNT;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int COLS_USED   = (GLYPH_COLS < 8) ? GLYPH_COLS : 8;
    localparam int ROWS_USED   = (GLYPH_ROWS < 8) ? GLYPH_ROWS : 8;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CELL,
        S_PIX,
        S_WRITE
    } t_state;

    t_state               r_state, n_state;
    logic [ADDR_W-1:0]    r_clr_addr, n_clr_addr;
    logic                 r_report, n_report;
    logic                 r_done, n_done;
    logic [BYTE_W-1:0]    r_read_byte, n_read_byte;
    logic                 r_is_read, n_is_read;
    logic [SCALE_W-1:0]   r_scale;
    logic [SCALE_W-1:0]   r_s, n_s;
    logic [GLYPH_W-1:0]   r_glyph, n_glyph;
    logic                 r_on, n_on;
    logic                 r_single, n_single;
    logic [COORD_W-1:0]   r_y0, n_y0;
    logic [COORD_W-1:0]   r_cell_x, n_cell_x;
    logic [COORD_W-1:0]   r_cell_y, n_cell_y;
    logic [COORD_W-1:0]   r_px, n_px;
    logic [COORD_W-1:0]   r_py, n_py;
    logic [2:0]           r_col, n_col;
    logic [2:0]           r_row, n_row;
    logic [SCALE_W-1:0]   r_dx, n_dx;
    logic [SCALE_W-1:0]   r_dy, n_dy;

    logic                 ram_we;
    logic                 ram_re;
    logic [ADDR_W-1:0]    ram_addr;
    logic [BYTE_W-1:0]    ram_wdata;
    logic [BYTE_W-1:0]    ram_rdata;

    logic                 in_frame;
    logic [ADDR_W-1:0]    pix_addr;
    logic [BYTE_W-1:0]    pix_mask;
    logic [5:0]           bit_idx;
    logic                 cell_lit;
    logic                 read_in_range;
    logic                 step_pix;
    logic                 step_cell;

    sgb_frame_ram #(
        .DEPTH  (STORE_BYTES),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Address and bit of the current pixel in page order.
    assign in_frame = (32'(r_px) < FRAME_WIDTH) && (32'(r_py) < FRAME_HEIGHT);
    assign pix_addr = ADDR_W'(32'(r_py[COORD_W-1:3]) * FRAME_WIDTH + 32'(r_px));
    assign pix_mask = BYTE_W'(1) << r_py[2:0];

    // Glyph cell (col,row) lives at bit col*8+row; bits past the field read as zero.
    assign bit_idx  = {r_col, r_row};
    assign cell_lit = (32'(bit_idx) < GLYPH_W) ? r_glyph[bit_idx] : 1'b0;

    assign read_in_range = 32'(i_byte_index) < STORE_BYTES;

    // Sequencer next state and memory port control.
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_report    = r_report;
        n_done      = 1'b0;
        n_read_byte = '0;
        n_is_read   = 1'b0;
        n_s         = r_s;
        n_glyph     = r_glyph;
        n_on        = r_on;
        n_single    = r_single;
        n_y0        = r_y0;
        n_cell_x    = r_cell_x;
        n_cell_y    = r_cell_y;
        n_px        = r_px;
        n_py        = r_py;
        n_col       = r_col;
        n_row       = r_row;
        n_dx        = r_dx;
        n_dy        = r_dy;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_addr    = '0;
        ram_wdata   = '0;
        step_pix    = 1'b0;
        step_cell   = 1'b0;

        case (r_state)
            S_CLEAR: begin
                ram_we   = 1'b1;
                ram_addr = r_clr_addr;
                if (r_clr_addr == LAST_ADDR) begin
                    n_done  = r_report;
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (start) begin
                    case (t_func'(i_func))
                        FUNC_CLEAR: begin
                            n_clr_addr = '0;
                            n_report   = 1'b1;
                            n_state    = S_CLEAR;
                        end
                        FUNC_PIXEL: begin
                            n_px     = COORD_W'(i_pos_x);
                            n_py     = COORD_W'(i_pos_y);
                            n_on     = i_pixel_on;
                            n_single = 1'b1;
                            n_state  = S_PIX;
                        end
                        FUNC_GLYPH: begin
                            n_glyph  = i_glyph_bits;
                            n_y0     = COORD_W'(i_pos_y);
                            n_cell_x = COORD_W'(i_pos_x);
                            n_cell_y = COORD_W'(i_pos_y);
                            n_col    = '0;
                            n_row    = '0;
                            n_s      = r_scale;
                            n_on     = 1'b1;
                            n_single = 1'b0;
                            if (r_scale == '0) begin
                                n_done = 1'b1;
                            end else begin
                                n_state = S_CELL;
                            end
                        end
                        FUNC_READ: begin
                            if (read_in_range) begin
                                ram_re   = 1'b1;
                                ram_addr = ADDR_W'(i_byte_index);
                                n_state  = S_READ;
                            end else begin
                                n_done    = 1'b1;
                                n_is_read = 1'b1;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_done      = 1'b1;
                n_is_read   = 1'b1;
                n_read_byte = ram_rdata;
                n_state     = S_IDLE;
            end
            S_CELL: begin
                if (cell_lit) begin
                    n_dx    = '0;
                    n_dy    = '0;
                    n_px    = r_cell_x;
                    n_py    = r_cell_y;
                    n_state = S_PIX;
                end else begin
                    step_cell = 1'b1;
                end
            end
            S_PIX: begin
                if (in_frame) begin
                    ram_re   = 1'b1;
                    ram_addr = pix_addr;
                    n_state  = S_WRITE;
                end else begin
                    step_pix = 1'b1;
                end
            end
            S_WRITE: begin
                ram_we    = 1'b1;
                ram_addr  = pix_addr;
                ram_wdata = r_on ? (ram_rdata | pix_mask) : (ram_rdata & ~pix_mask);
                step_pix  = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Move to the next pixel of the block, or finish a single pixel.
        if (step_pix) begin
            if (r_single) begin
                n_done  = 1'b1;
                n_state = S_IDLE;
            end else if ({1'b0, r_dx} + 1'b1 < {1'b0, r_s}) begin
                n_dx    = r_dx + 1'b1;
                n_px    = r_px + 1'b1;
                n_state = S_PIX;
            end else if ({1'b0, r_dy} + 1'b1 < {1'b0, r_s}) begin
                n_dx    = '0;
                n_px    = r_cell_x;
                n_dy    = r_dy + 1'b1;
                n_py    = r_py + 1'b1;
                n_state = S_PIX;
            end else begin
                step_cell = 1'b1;
            end
        end

        // Move to the next glyph cell, rows within a column first.
        if (step_cell) begin
            if (32'(r_row) + 1 < ROWS_USED) begin
                n_row    = r_row + 1'b1;
                n_cell_y = r_cell_y + COORD_W'(r_s);
                n_state  = S_CELL;
            end else if (32'(r_col) + 1 < COLS_USED) begin
                n_row    = '0;
                n_cell_y = r_y0;
                n_col    = r_col + 1'b1;
                n_cell_x = r_cell_x + COORD_W'(r_s);
                n_state  = S_CELL;
            end else begin
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
        end
    end

    // State, working registers and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_report   <= 1'b0;
            r_done     <= 1'b0;
            r_scale    <= SCALE_RESET;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_report   <= n_report;
            r_done     <= n_done;
            if (i_cfg_we) begin
                r_scale <= i_cfg_wdata;
            end
        end
        r_read_byte <= n_read_byte;
        r_is_read   <= n_is_read;
        r_s         <= n_s;
        r_glyph     <= n_glyph;
        r_on        <= n_on;
        r_single    <= n_single;
        r_y0        <= n_y0;
        r_cell_x    <= n_cell_x;
        r_cell_y    <= n_cell_y;
        r_px        <= n_px;
        r_py        <= n_py;
        r_col       <= n_col;
        r_row       <= n_row;
        r_dx        <= n_dx;
        r_dy        <= n_dy;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_read_byte = r_read_byte;
    assign o_is_read   = r_is_read;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for scaled_glyph_blitter: directed and random items,
// checked against an in-bench frame image model of the page-ordered buffer.
// Depends on sgb_pkg and the scaled_glyph_blitter RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sgb_pkg::*;

    localparam int FRAME_W     = DEF_FRAME_WIDTH;
    localparam int FRAME_H     = DEF_FRAME_HEIGHT;
    localparam int GLYPH_C     = DEF_GLYPH_COLS;
    localparam int GLYPH_R     = DEF_GLYPH_ROWS;
    localparam int BANDS       = (FRAME_H + BAND_ROWS - 1) / BAND_ROWS;
    localparam int STORE_BYTES = FRAME_W * BANDS;

    typedef struct {
        t_func              op;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic               on;
        logic [GLYPH_W-1:0] bits;
        logic [POS_W-1:0]   idx;
    } t_blit_cmd;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              is_read;
    } t_blit_reply;

    // DUT connections; the inputs are driven to known values from time zero.
    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               start        = 1'b0;
    logic               busy;
    logic               i_cfg_we     = 1'b0;
    logic [SCALE_W-1:0] i_cfg_wdata  = '0;
    logic [FUNC_W-1:0]  i_func       = '0;
    logic [POS_W-1:0]   i_pos_x      = '0;
    logic [POS_W-1:0]   i_pos_y      = '0;
    logic               i_pixel_on   = 1'b0;
    logic [GLYPH_W-1:0] i_glyph_bits = '0;
    logic [POS_W-1:0]   i_byte_index = '0;
    logic               o_done;
    logic [BYTE_W-1:0]  o_read_byte;
    logic               o_is_read;

    // Model state: the frame image and the current magnification.
    logic [BYTE_W-1:0]  frame_image [STORE_BYTES];
    logic [SCALE_W-1:0] model_scale;

    t_blit_reply expected_replies[$];
    int          err_count    = 0;
    int          op_count [4] = '{default: 0};
    int          lit_reads    = 0;
    bit          tight_timing = 1'b0;
    int          hot_x        = 0;
    int          hot_y        = 0;

    scaled_glyph_blitter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_func       (i_func),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pixel_on   (i_pixel_on),
        .i_glyph_bits (i_glyph_bits),
        .i_byte_index (i_byte_index),
        .o_done       (o_done),
        .o_read_byte  (o_read_byte),
        .o_is_read    (o_is_read)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Overall time limit; far beyond the slowest legal run.
    initial begin
        #100_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Set or clear one pixel of the image; off-frame pixels are dropped.
    function automatic void plot_pixel(int x, int y, bit lit);
        int addr;
        if (x >= FRAME_W || y >= FRAME_H) return;
        addr = (y / BAND_ROWS) * FRAME_W + x;
        frame_image[addr][y % BAND_ROWS] = lit;
    endfunction

    // Every lit glyph cell becomes an s by s block of set pixels.
    function automatic void stamp_glyph(logic [GLYPH_W-1:0] bits, int x, int y, int s);
        for (int c = 0; c < GLYPH_C && c < 8; c++) begin
            for (int r = 0; r < GLYPH_R && r < 8; r++) begin
                if (bits[c*8 + r]) begin
                    for (int dy = 0; dy < s; dy++) begin
                        for (int dx = 0; dx < s; dx++) begin
                            plot_pixel(x + c*s + dx, y + r*s + dy, 1'b1);
                        end
                    end
                end
            end
        end
    endfunction

    // Apply one item to the image and return the reply it should produce.
    function automatic t_blit_reply apply_cmd(t_blit_cmd c);
        t_blit_reply r;
        r.data    = '0;
        r.is_read = 1'b0;
        case (c.op)
            FUNC_CLEAR: begin
                foreach (frame_image[i]) frame_image[i] = '0;
            end
            FUNC_PIXEL: begin
                plot_pixel(int'(c.x), int'(c.y), c.on);
            end
            FUNC_GLYPH: begin
                stamp_glyph(c.bits, int'(c.x), int'(c.y), int'(model_scale));
            end
            default: begin
                r.is_read = 1'b1;
                if (int'(c.idx) < STORE_BYTES) r.data = frame_image[c.idx];
            end
        endcase
        return r;
    endfunction

    // An item of the given operation with every field random.
    function automatic t_blit_cmd scramble(t_func op);
        t_blit_cmd   c;
        logic [63:0] w;
        w      = {$urandom, $urandom};
        c.op   = op;
        c.x    = POS_W'($urandom);
        c.y    = POS_W'($urandom);
        c.on   = 1'($urandom);
        c.bits = w[GLYPH_W-1:0];
        c.idx  = POS_W'($urandom);
        return c;
    endfunction

    // Mostly inside the frame, sometimes anywhere in the field's range.
    function automatic int rand_coord(int span);
        if ($urandom_range(0, 99) < 85) return $urandom_range(0, span - 1);
        return $urandom_range(0, 1023);
    endfunction

    // Random item; reads lean towards the area most recently drawn.
    function automatic t_blit_cmd random_cmd();
        t_blit_cmd   c;
        int          pick;
        int          s;
        int          rx;
        int          ry;
        logic [63:0] w;
        pick = $urandom_range(0, 99);
        s    = (model_scale == 0) ? 1 : int'(model_scale);
        if (pick < 3) begin
            c = scramble(FUNC_CLEAR);
        end else if (pick < 33) begin
            c   = scramble(FUNC_PIXEL);
            c.x = POS_W'(rand_coord(FRAME_W));
            c.y = POS_W'(rand_coord(FRAME_H));
            if ($urandom_range(0, 3) != 0 && hot_x < FRAME_W && hot_y < FRAME_H) begin
                c.x = POS_W'(hot_x + $urandom_range(0, 3));
                c.y = POS_W'(hot_y + $urandom_range(0, 7));
            end
            hot_x = int'(c.x);
            hot_y = int'(c.y);
        end else if (pick < 60) begin
            c   = scramble(FUNC_GLYPH);
            c.x = POS_W'(rand_coord(FRAME_W));
            c.y = POS_W'(rand_coord(FRAME_H));
            w   = {$urandom, $urandom};
            case ($urandom_range(0, 3))
                0: c.bits = c.bits & w[GLYPH_W-1:0];
                1: c.bits = GLYPH_W'(1) << $urandom_range(0, GLYPH_W - 1);
                default: ;
            endcase
            hot_x = int'(c.x);
            hot_y = int'(c.y);
        end else begin
            c  = scramble(FUNC_READ);
            rx = hot_x + $urandom_range(0, GLYPH_C * s);
            ry = hot_y + $urandom_range(0, GLYPH_R * s);
            if ($urandom_range(0, 99) < 60 && rx < FRAME_W && ry < FRAME_H) begin
                c.idx = POS_W'((ry / BAND_ROWS) * FRAME_W + rx);
            end
        end
        return c;
    endfunction

    // Gap before an item: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (tight_timing) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 80);
    endfunction

    // Present one item and hold it until the block takes it.
    task automatic send_cmd(input t_blit_cmd c);
        int          gap;
        t_blit_reply r;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_func       <= c.op;
        i_pos_x      <= c.x;
        i_pos_y      <= c.y;
        i_pixel_on   <= c.on;
        i_glyph_bits <= c.bits;
        i_byte_index <= c.idx;
        do @(posedge i_clk); while (busy !== 1'b0);
        r = apply_cmd(c);
        expected_replies.push_back(r);
        op_count[c.op]++;
        if (r.is_read && r.data != 0) lit_reads++;
    endtask

    // Stop sending and wait until every reply is in and the block is idle.
    task automatic drain_block();
        start <= 1'b0;
        do @(posedge i_clk); while (expected_replies.size() != 0 || busy !== 1'b0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_scale(input logic [SCALE_W-1:0] s);
        drain_block();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= s;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        model_scale  = s;
    endtask

    task automatic send_pixel(input int x, input int y, input bit lit);
        t_blit_cmd c;
        c    = scramble(FUNC_PIXEL);
        c.x  = POS_W'(x);
        c.y  = POS_W'(y);
        c.on = lit;
        send_cmd(c);
    endtask

    task automatic send_glyph(input int x, input int y, input logic [GLYPH_W-1:0] bits);
        t_blit_cmd c;
        c      = scramble(FUNC_GLYPH);
        c.x    = POS_W'(x);
        c.y    = POS_W'(y);
        c.bits = bits;
        send_cmd(c);
    endtask

    task automatic send_read(input int idx);
        t_blit_cmd c;
        c     = scramble(FUNC_READ);
        c.idx = POS_W'(idx);
        send_cmd(c);
    endtask

    task automatic send_clear();
        send_cmd(scramble(FUNC_CLEAR));
    endtask

    // The buffer must read back as zero once the reset clearing pass is over.
    task automatic test_reset_state();
        send_read(0);
        send_read(STORE_BYTES - 1);
    endtask

    // Frame corners, clearing a pixel, and pixels just past each edge.
    task automatic test_pixel_edges();
        send_pixel(0, 0, 1'b1);
        send_pixel(FRAME_W - 1, FRAME_H - 1, 1'b1);
        send_pixel(FRAME_W, 0, 1'b1);
        send_pixel(0, FRAME_H, 1'b1);
        send_pixel(1023, 1023, 1'b1);
        send_read(0);
        send_read(STORE_BYTES - 1);
        send_pixel(FRAME_W - 1, FRAME_H - 1, 1'b0);
        send_read(STORE_BYTES - 1);
    endtask

    // Glyphs at the reset scale, at scale zero, at the largest scale with
    // clipping at the frame edge, and at scale eight.
    task automatic test_glyph_scales();
        send_glyph(0, 8, {GLYPH_W{1'b1}});
        send_read(FRAME_W);
        write_scale(4'd0);
        send_glyph(10, 0, {GLYPH_W{1'b1}});
        send_read(10);
        write_scale(4'd15);
        send_glyph(100, 40, {GLYPH_W{1'b1}});
        send_read(5 * FRAME_W + 110);
        write_scale(4'd8);
        send_glyph(64, 0, 40'h5A_C3_81_FF_24);
        send_read(64);
    endtask

    task automatic test_clear_frame();
        send_clear();
        send_read(FRAME_W);
        send_read(STORE_BYTES - 1);
    endtask

    // One random phase at a fixed scale; halfway through the sender waits
    // for every outstanding reply before carrying on.
    task automatic test_random_traffic(input logic [SCALE_W-1:0] s, input int n,
                                       input bit tight);
        write_scale(s);
        tight_timing = tight;
        for (int i = 0; i < n; i++) begin
            if (i == n / 2) drain_block();
            send_cmd(random_cmd());
        end
        tight_timing = 1'b0;
    endtask

    // Result checker: every strobe is matched against the oldest expectation.
    always @(posedge i_clk) begin
        t_blit_reply exp_r;
        if (i_rst_n && o_done === 1'b1) begin
            if (expected_replies.size() == 0) begin
                $error("unexpected result: read_byte %0h is_read %0b", o_read_byte, o_is_read);
                err_count++;
            end else begin
                exp_r = expected_replies.pop_front();
                if (o_read_byte !== exp_r.data) begin
                    $error("read_byte: expected %0h, got %0h", exp_r.data, o_read_byte);
                    err_count++;
                end
                if (o_is_read !== exp_r.is_read) begin
                    $error("is_read: expected %0b, got %0b", exp_r.is_read, o_is_read);
                    err_count++;
                end
            end
        end
    end

    initial begin
        foreach (frame_image[i]) frame_image[i] = '0;
        model_scale = SCALE_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_pixel_edges();
        test_glyph_scales();
        test_clear_frame();

        test_random_traffic(4'd1, 70, 1'b1);
        test_random_traffic(4'd2, 66, 1'b0);
        test_random_traffic(4'd3, 66, 1'b0);
        test_random_traffic(4'd4, 66, 1'b0);
        test_random_traffic(4'd8, 60, 1'b0);
        test_random_traffic(4'd5, 66, 1'b0);
        test_random_traffic(4'd2, 66, 1'b1);
        test_random_traffic(4'd1, 70, 1'b0);

        // Let the last item finish and watch for stray strobes.
        drain_block();
        repeat (64) @(posedge i_clk);

        $display("Run covered %0d clears, %0d pixel writes, %0d glyph draws, %0d reads",
                 op_count[FUNC_CLEAR], op_count[FUNC_PIXEL], op_count[FUNC_GLYPH],
                 op_count[FUNC_READ]);
        $display("Scales 0, 1, 2, 3, 4, 5, 8 and 15 used; %0d reads returned lit bytes",
                 lit_reads);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/sgb_pkg.sv
hw/rtl/sgb_frame_ram.sv
hw/rtl/scaled_glyph_blitter.sv
tb/tb_top.sv
